/* hw/rtl/bfac_pkg.sv */
package bfac_pkg;

    localparam int unsigned FILTER_BITS_DEF = 8192;
    localparam int unsigned ROW_BITS        = 32;
    localparam int unsigned CFG_AW          = 3;
    localparam int unsigned CFG_DW          = 32;

    localparam logic [3:0]  HC_RESET   = 4'd7;
    localparam logic [3:0]  MAX_HASHES = 4'd8;

    // register index, taken from paddr[2]
    localparam logic        REG_HASH_COUNT = 1'b0;

    localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_P1      = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] MIX_P2      = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] MIX_P4      = 64'h27D4_EB2F_1656_67C5;
    localparam logic [63:0] FIN_M1      = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FIN_M2      = 64'hC4CE_B9FE_1A85_EC53;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_KP_MUL,
        S_KP_SUM,
        S_PRE,
        S_P1_MUL,
        S_P1_SUM,
        S_M1_MUL,
        S_M1_SUM,
        S_M2_MUL,
        S_M2_SUM,
        S_READ,
        S_TEST,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_KEY_P2,
        MUL_P1,
        MUL_M1,
        MUL_M2
    } t_mul_op;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    mul_go;
        t_mul_op mul_op;
        logic    kp_wr;
        logic    acc_pre;
        logic    acc_mul;
        logic    rd_en;
        logic    test;
        logic    next_pos;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic n_zero;
        logic is_check;
        logic last;
        logic miss;
        logic out_free;
    } t_stat;

    function automatic logic [63:0] rotl31(input logic [63:0] v);
        rotl31 = {v[32:0], v[63:33]};
    endfunction

    function automatic logic [63:0] xs33(input logic [63:0] v);
        xs33 = v ^ {33'b0, v[63:33]};
    endfunction

endpackage

/* hw/rtl/bfac_in_if.sv */
interface bfac_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

/* hw/rtl/bfac_out_if.sv */
interface bfac_out_if;
    logic valid;
    logic ready;
    logic maybe_present;

    modport source (output valid, output maybe_present, input ready);
    modport sink   (input valid, input maybe_present, output ready);
endinterface

/* hw/rtl/bfac_ctrl.sv */
module bfac_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bfac_pkg::t_stat i_stat,
    output bfac_pkg::t_cmd  o_cmd
);

    bfac_pkg::t_state r_state;
    bfac_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfac_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_op = bfac_pkg::MUL_KEY_P2;
        unique case (r_state)
            bfac_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = bfac_pkg::S_IDLE;
                end
            end
            bfac_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bfac_pkg::S_KP_MUL;
                end
            end
            bfac_pkg::S_KP_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = bfac_pkg::MUL_KEY_P2;
                n_state      = bfac_pkg::S_KP_SUM;
            end
            bfac_pkg::S_KP_SUM: begin
                o_cmd.kp_wr = 1'b1;
                if (!i_stat.n_zero) begin
                    n_state = bfac_pkg::S_PRE;
                end else if (i_stat.is_check) begin
                    n_state = bfac_pkg::S_OUT;
                end else begin
                    n_state = bfac_pkg::S_IDLE;
                end
            end
            bfac_pkg::S_PRE: begin
                o_cmd.acc_pre = 1'b1;
                n_state       = bfac_pkg::S_P1_MUL;
            end
            bfac_pkg::S_P1_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = bfac_pkg::MUL_P1;
                n_state      = bfac_pkg::S_P1_SUM;
            end
            bfac_pkg::S_P1_SUM: begin
                o_cmd.acc_mul = 1'b1;
                n_state       = bfac_pkg::S_M1_MUL;
            end
            bfac_pkg::S_M1_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = bfac_pkg::MUL_M1;
                n_state      = bfac_pkg::S_M1_SUM;
            end
            bfac_pkg::S_M1_SUM: begin
                o_cmd.acc_mul = 1'b1;
                n_state       = bfac_pkg::S_M2_MUL;
            end
            bfac_pkg::S_M2_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = bfac_pkg::MUL_M2;
                n_state      = bfac_pkg::S_M2_SUM;
            end
            bfac_pkg::S_M2_SUM: begin
                o_cmd.acc_mul = 1'b1;
                n_state       = bfac_pkg::S_READ;
            end
            bfac_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = bfac_pkg::S_TEST;
            end
            bfac_pkg::S_TEST: begin
                o_cmd.test = 1'b1;
                if (i_stat.miss || i_stat.last) begin
                    n_state = i_stat.is_check ? bfac_pkg::S_OUT : bfac_pkg::S_IDLE;
                end else begin
                    o_cmd.next_pos = 1'b1;
                    n_state        = bfac_pkg::S_PRE;
                end
            end
            bfac_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bfac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfac_pkg::S_IDLE;
            end
        endcase
    end

    // no transaction may slip in while the store is being wiped
    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfac_pkg::S_CLEAR) |-> !o_cmd.load)
        else $error("item accepted during clear pass");

endmodule

/* hw/rtl/bfac_dpath.sv */
module bfac_dpath #(
    parameter int unsigned FILTER_BITS = bfac_pkg::FILTER_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bfac_pkg::t_cmd  i_cmd,
    output bfac_pkg::t_stat o_stat,
    input  logic            i_kind,
    input  logic [63:0]     i_key,
    input  logic [3:0]      i_hash_count,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_maybe_present
);

    localparam int unsigned ROWS  = FILTER_BITS / bfac_pkg::ROW_BITS;
    localparam int unsigned ROW_W = $clog2(ROWS);
    localparam int unsigned SEL_W = $clog2(bfac_pkg::ROW_BITS);
    localparam int unsigned IDX_W = $clog2(FILTER_BITS);

    logic [63:0] r_key;
    logic        r_is_check;
    logic [3:0]  r_n;
    logic [2:0]  r_i;
    logic [63:0] r_seed;
    logic [63:0] r_kp;
    logic [63:0] r_acc;
    logic [63:0] r_p_ll;
    logic [31:0] r_p_lh;
    logic [31:0] r_p_hl;
    logic        r_hit;
    logic        r_out_valid;
    logic        r_out_bit;
    logic [ROW_W-1:0] r_clr_cnt;
    logic [bfac_pkg::ROW_BITS-1:0] r_rd_data;
    logic [bfac_pkg::ROW_BITS-1:0] mem [ROWS];

    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_sum;
    logic [63:0] idx_hash;
    logic [IDX_W-1:0] bit_idx;
    logic [ROW_W-1:0] row;
    logic [SEL_W-1:0] sel;
    logic        hit_bit;
    logic        mem_we;
    logic [ROW_W-1:0] mem_wa;
    logic [bfac_pkg::ROW_BITS-1:0] mem_wd;

    always_comb begin
        unique case (i_cmd.mul_op)
            bfac_pkg::MUL_KEY_P2: begin
                mul_a = r_key;
                mul_b = bfac_pkg::MIX_P2;
            end
            bfac_pkg::MUL_P1: begin
                mul_a = r_acc;
                mul_b = bfac_pkg::MIX_P1;
            end
            bfac_pkg::MUL_M1: begin
                mul_a = bfac_pkg::xs33(r_acc);
                mul_b = bfac_pkg::FIN_M1;
            end
            bfac_pkg::MUL_M2: begin
                mul_a = bfac_pkg::xs33(r_acc);
                mul_b = bfac_pkg::FIN_M2;
            end
            default: begin
                mul_a = r_key;
                mul_b = bfac_pkg::MIX_P2;
            end
        endcase
    end

    // low 64 bits of a 64x64 product from three 32x32 partials
    assign mul_sum  = r_p_ll + {r_p_lh + r_p_hl, 32'b0};
    assign idx_hash = bfac_pkg::xs33(r_acc);
    assign bit_idx  = idx_hash[IDX_W-1:0];
    assign row      = bit_idx[IDX_W-1:SEL_W];
    assign sel      = bit_idx[SEL_W-1:0];
    assign hit_bit  = r_rd_data[sel];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_p_ll <= 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
            r_p_lh <= mul_a[31:0] * mul_b[63:32];
            r_p_hl <= mul_a[63:32] * mul_b[31:0];
        end
        if (i_cmd.load) begin
            r_key      <= i_key;
            r_is_check <= i_kind;
            r_seed     <= bfac_pkg::MIX_P4;
            r_hit      <= 1'b1;
        end
        if (i_cmd.kp_wr) begin
            r_kp <= mul_sum;
        end
        if (i_cmd.acc_pre) begin
            r_acc <= bfac_pkg::rotl31(r_seed + r_kp);
        end else if (i_cmd.acc_mul) begin
            r_acc <= mul_sum;
        end
        if (i_cmd.next_pos) begin
            r_seed <= r_seed + bfac_pkg::GOLDEN_STEP;
        end
        if (i_cmd.test && r_is_check && !hit_bit) begin
            r_hit <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_bit <= r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
            r_clr_cnt   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_n <= (i_hash_count > bfac_pkg::MAX_HASHES) ? bfac_pkg::MAX_HASHES
                                                            : i_hash_count;
                r_i <= '0;
            end else if (i_cmd.next_pos) begin
                r_i <= r_i + 3'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    assign mem_we = i_cmd.clr || (i_cmd.test && !r_is_check);
    assign mem_wa = i_cmd.clr ? r_clr_cnt : row;
    assign mem_wd = i_cmd.clr ? '0
                  : (r_rd_data | ({{(bfac_pkg::ROW_BITS-1){1'b0}}, 1'b1} << sel));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[row];
        end
    end

    assign o_stat.clr_last = (r_clr_cnt == ROW_W'(ROWS - 1));
    assign o_stat.n_zero   = (r_n == 4'd0);
    assign o_stat.is_check = r_is_check;
    assign o_stat.last     = ({1'b0, r_i} == (r_n - 4'd1));
    assign o_stat.miss     = r_is_check && !hit_bit;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_maybe_present = r_out_bit;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.test |-> ({1'b0, r_i} < r_n))
        else $error("hash position beyond hash count");

    a_result_only_for_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> r_is_check)
        else $error("result issued for an add");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("output valid without a finished check");

endmodule

/* hw/rtl/bloom_filter_add_check.sv */
// Bloom filter over 64-bit keys: each input transaction adds a key (no result) or checks it
// (one result, maybe_present). hash_count (register 0, reset 7, values above 8 act as 8) sets
// the hash positions per key. After reset the bit store is wiped, one 32-bit row a cycle,
// before the first transaction is accepted. Items are processed one at a time; a check stops
// at its first miss. Each position is one seed add, three multiplies on the shared 64-bit
// multiplier (partials, then sum), then a read and a test/write on the single-port row
// memory. A finished result sits in an output register, so the next transaction is accepted
// while it waits; a check holds in its last cycle for as long as the previous result is
// still unaccepted.
module bloom_filter_add_check #(
    parameter int unsigned FILTER_BITS = bfac_pkg::FILTER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfac_in_if.sink                       i_in,
    bfac_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfac_pkg::CFG_AW-1:0]   paddr,
    input  logic [bfac_pkg::CFG_DW-1:0]   pwdata,
    output logic [bfac_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    logic [3:0]      r_hash_count;
    bfac_pkg::t_cmd  cmd;
    bfac_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count <= bfac_pkg::HC_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == bfac_pkg::REG_HASH_COUNT)) begin
            r_hash_count <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bfac_pkg::REG_HASH_COUNT)
                  ? {{(bfac_pkg::CFG_DW-4){1'b0}}, r_hash_count} : '0;

    bfac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfac_dpath #(
        .FILTER_BITS (FILTER_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_in.kind),
        .i_key           (i_in.key),
        .i_hash_count    (r_hash_count),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_maybe_present (o_out.maybe_present)
    );

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FILTER_BITS = 8192;
    localparam int unsigned POS_W       = $clog2(FILTER_BITS);
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 100;

    localparam bit KIND_ADD   = 1'b0;
    localparam bit KIND_CHECK = 1'b1;

    localparam logic [bfac_pkg::CFG_AW-1:0] ADDR_HASH_COUNT = {bfac_pkg::REG_HASH_COUNT, 2'b00};
    localparam logic [bfac_pkg::CFG_AW-1:0] ADDR_UNMAPPED   = {~bfac_pkg::REG_HASH_COUNT, 2'b00};

    localparam bit [3:0]  HASH_COUNT_RESET = 4'd7;
    localparam bit [3:0]  HASH_LIMIT       = 4'd8;
    localparam bit [63:0] SEED_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam bit [63:0] PRIME1    = 64'h9E37_79B1_85EB_CA87;
    localparam bit [63:0] PRIME2    = 64'hC2B2_AE3D_27D4_EB4F;
    localparam bit [63:0] PRIME4    = 64'h27D4_EB2F_1656_67C5;
    localparam bit [63:0] FMIX_A    = 64'hFF51_AFD7_ED55_8CCD;
    localparam bit [63:0] FMIX_B    = 64'hC4CE_B9FE_1A85_EC53;

    class bloom_scoreboard;
        bit [FILTER_BITS-1:0] filter_bits;
        bit [3:0]             hash_count;
        bit                   presence_q[$];
        int                   errors;

        function new();
            filter_bits = '0;
            hash_count  = HASH_COUNT_RESET;
            errors      = 0;
        endfunction

        function int pending();
            return presence_q.size();
        endfunction

        function void set_hash_count(bit [3:0] value);
            hash_count = value;
        endfunction

        function bit [POS_W-1:0] bit_position(bit [63:0] key, int unsigned idx);
            bit [63:0] h;
            h = 64'(idx) * SEED_STEP + PRIME4 + key * PRIME2;
            h = {h[32:0], h[63:33]} * PRIME1;
            h = h ^ (h >> 33);
            h = h * FMIX_A;
            h = h ^ (h >> 33);
            h = h * FMIX_B;
            h = h ^ (h >> 33);
            return h[POS_W-1:0];
        endfunction

        // add sets the hashed bits; check queues whether they were all set
        function void note_input(bit kind, bit [63:0] key);
            int unsigned  n;
            bit           hit;
            bit [POS_W-1:0] pos;
            n   = (hash_count > HASH_LIMIT) ? HASH_LIMIT : hash_count;
            hit = 1'b1;
            for (int unsigned i = 0; i < n; i++) begin
                pos = bit_position(key, i);
                if (kind == KIND_ADD)
                    filter_bits[pos] = 1'b1;
                else if (!filter_bits[pos])
                    hit = 1'b0;
            end
            if (kind == KIND_CHECK)
                presence_q.push_back(hit);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic got);
            bit want;
            if (presence_q.size() == 0) begin
                report($sformatf("result %b with no check pending", got));
                return;
            end
            want = presence_q.pop_front();
            if (got !== want)
                report($sformatf("maybe_present got %b expected %b", got, want));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bfac_pkg::CFG_AW-1:0] paddr;
    logic [bfac_pkg::CFG_DW-1:0] pwdata;
    logic [bfac_pkg::CFG_DW-1:0] prdata;
    logic pready;

    bfac_in_if  in_if();
    bfac_out_if out_if();

    bloom_filter_add_check #(
        .FILTER_BITS(FILTER_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bloom_scoreboard sb;
    bit              idle_on;
    int unsigned     stall_left = 0;
    int unsigned     stuck_cycles = 0;
    logic [63:0]     added_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sink side: random backpressure bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 13);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.kind, in_if.key);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.maybe_present);
        end
    end

    // watchdog: cycles with no transaction and no register write
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (psel && penable && pwrite && pready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [63:0] random_key();
        if ($urandom_range(0, 4) == 0)
            return 64'($urandom_range(0, 255));
        return {$urandom, $urandom};
    endfunction

    // valid stays high across back-to-back transactions; dropped only for a gap
    task automatic send_item(input bit kind, input logic [63:0] key);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind  <= kind;
        in_if.key   <= key;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // adds give no result, so allow the last one to finish after the queue empties;
    // the first clock wait lets the monitor log the last accepted transaction
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bfac_pkg::CFG_AW-1:0] addr, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {28'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_HASH_COUNT)
            sb.set_hash_count(value);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned sel;
        bit          kind;
        logic [63:0] key;
        for (int unsigned n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40 || added_keys.size() == 0) begin
                kind = KIND_ADD;
                key  = random_key();
                added_keys.push_back(key);
                if (added_keys.size() > 64)
                    void'(added_keys.pop_front());
            end else if (sel < 75) begin
                kind = KIND_CHECK;
                key  = added_keys[$urandom_range(0, added_keys.size() - 1)];
            end else if (sel < 90) begin
                kind = KIND_CHECK;
                key  = random_key();
            end else begin
                // near misses: a known key with one bit flipped
                kind = ($urandom_range(0, 1) == 0) ? KIND_ADD : KIND_CHECK;
                key  = added_keys[$urandom_range(0, added_keys.size() - 1)]
                       ^ (64'd1 << $urandom_range(0, 63));
            end
            send_item(kind, key);
        end
    endtask

    initial begin
        bit [3:0] hash_settings[11];
        logic [63:0] k;
        hash_settings = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd12, 4'd5, 4'd3, 4'd6, 4'd4, 4'd7};
        sb = new();
        idle_on      = 1'b1;
        in_if.valid  <= 1'b0;
        in_if.kind   <= KIND_ADD;
        in_if.key    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset hash count, empty filter first
        send_item(KIND_CHECK, 64'd0);
        send_item(KIND_CHECK, '1);
        send_item(KIND_ADD, 64'd0);
        send_item(KIND_ADD, '1);
        send_item(KIND_ADD, 64'd1);
        send_item(KIND_ADD, 64'h8000_0000_0000_0000);
        send_item(KIND_ADD, 64'h5555_5555_5555_5555);
        send_item(KIND_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_CHECK, 64'd0);
        send_item(KIND_CHECK, '1);
        send_item(KIND_CHECK, 64'h8000_0000_0000_0000);
        send_item(KIND_CHECK, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_CHECK, 64'd2);

        // zero hash count: nothing selected, check always hits
        drain();
        write_reg(ADDR_HASH_COUNT, 4'd0);
        k = {$urandom, $urandom};
        send_item(KIND_CHECK, k);
        send_item(KIND_ADD, k);

        // count above the limit behaves as the limit
        drain();
        write_reg(ADDR_HASH_COUNT, 4'd15);
        send_item(KIND_ADD, 64'h0123_4567_89AB_CDEF);
        send_item(KIND_CHECK, 64'h0123_4567_89AB_CDEF);
        send_item(KIND_CHECK, 64'h0123_4567_89AB_CDEE);

        // write to an unmapped register must leave the count alone
        drain();
        write_reg(ADDR_UNMAPPED, 4'd1);
        send_item(KIND_CHECK, 64'd2);

        drain();
        write_reg(ADDR_HASH_COUNT, 4'd1);
        send_item(KIND_ADD, 64'hDEAD_BEEF_CAFE_F00D);
        send_item(KIND_CHECK, 64'hDEAD_BEEF_CAFE_F00D);
        send_item(KIND_CHECK, 64'd3);

        foreach (hash_settings[p]) begin
            drain();
            write_reg(ADDR_HASH_COUNT, hash_settings[p]);
            if (p == $size(hash_settings) - 1)
                idle_on = 1'b0;
            run_random(95);
        end

        drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
